// ===== rtl/nioc_pkg.sv =====
// nioc_pkg: shared constants, codes and types of the index/offset converter.
// Depends on nothing; used by the interfaces and all modules.
`timescale 1ns / 1ps
package nioc_pkg;

  localparam int OFFSET_W        = 48;
  localparam int COORD_IN_W      = 13;
  localparam int COORD_OUT_W     = 12;
  localparam int EXT_FIELD_W     = 12;
  localparam int FIELD_AXES      = 4;
  localparam int NDIMS_W         = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 12;

  localparam int MAX_AXES_DEF    = 4;
  localparam int EXTENT_BITS_DEF = 12;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
  localparam int                   REG_EXT0     = 1;

  localparam logic ACT_SPLIT = 1'b0;
  localparam logic ACT_FOLD  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_DONE
  } nioc_state_e;

endpackage

// ===== rtl/nioc_in_if.sv =====
// nioc_in_if: input channel, one beat carries action, offset and coordinates.
// Depends on nioc_pkg for field widths.
`timescale 1ns / 1ps
interface nioc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic        [nioc_pkg::OFFSET_W-1:0]   lin_offset;
  logic signed [nioc_pkg::COORD_IN_W-1:0] coord_in0;
  logic signed [nioc_pkg::COORD_IN_W-1:0] coord_in1;
  logic signed [nioc_pkg::COORD_IN_W-1:0] coord_in2;
  logic signed [nioc_pkg::COORD_IN_W-1:0] coord_in3;

  modport source (output valid, action, lin_offset, coord_in0, coord_in1, coord_in2,
                  coord_in3, input ready);
  modport sink   (input valid, action, lin_offset, coord_in0, coord_in1, coord_in2,
                  coord_in3, output ready);
endinterface

// ===== rtl/nioc_out_if.sv =====
// nioc_out_if: result channel, one beat carries status, offset and coordinates.
// Depends on nioc_pkg for field widths.
`timescale 1ns / 1ps
interface nioc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [nioc_pkg::OFFSET_W-1:0]    offset_out;
  logic [nioc_pkg::COORD_OUT_W-1:0] coord_out0;
  logic [nioc_pkg::COORD_OUT_W-1:0] coord_out1;
  logic [nioc_pkg::COORD_OUT_W-1:0] coord_out2;
  logic [nioc_pkg::COORD_OUT_W-1:0] coord_out3;

  modport source (output valid, status, offset_out, coord_out0, coord_out1, coord_out2,
                  coord_out3, input ready);
  modport sink   (input valid, status, offset_out, coord_out0, coord_out1, coord_out2,
                  coord_out3, output ready);
endinterface

// ===== rtl/nioc_div.sv =====
// nioc_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on nioc_pkg for the dividend width.
`timescale 1ns / 1ps
module nioc_div #(
  parameter int DW = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nioc_pkg::OFFSET_W-1:0] n_i,
  input  logic [DW-1:0]                 d_i,
  output logic                          done_o,
  output logic [nioc_pkg::OFFSET_W-1:0] q_o,
  output logic [DW-1:0]                 r_o
);
  import nioc_pkg::*;

  localparam int NW = OFFSET_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] q_q;
  logic [DW-1:0] r_q;
  logic [DW-1:0] d_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {r_q, q_q[NW-1]};
  assign fits  = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= n_i;
      r_q <= '0;
      d_q <= d_i;
    end else if (busy_q) begin
      q_q <= {q_q[NW-2:0], fits};
      if (fits) begin
        r_q <= DW'(trial - {1'b0, d_q});
      end else begin
        r_q <= trial[DW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign r_o    = r_q;

endmodule

// ===== rtl/nioc_mul.sv =====
// nioc_mul: bit-serial shift-add multiply-accumulate, p = a * b + c.
// Depends on nioc_pkg for the accumulator width; one multiplier bit per cycle.
`timescale 1ns / 1ps
module nioc_mul #(
  parameter int BW = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nioc_pkg::OFFSET_W-1:0] a_i,
  input  logic [BW-1:0]                 b_i,
  input  logic [nioc_pkg::OFFSET_W-1:0] c_i,
  output logic                          done_o,
  output logic [nioc_pkg::OFFSET_W-1:0] p_o
);
  import nioc_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic                busy_q;
  logic                done_q;
  logic [CW-1:0]       cnt_q;
  logic [OFFSET_W-1:0] a_q;
  logic [BW-1:0]       b_q;
  logic [OFFSET_W-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= c_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== rtl/nd_index_offset_converter.sv =====
// nd_index_offset_converter: top level, config registers, sequencer, result register.
// Depends on nioc_pkg, nioc_in_if, nioc_out_if, nioc_div and nioc_mul.
//
// Converts a linear element offset into column-major coordinates (action 0)
// or coordinates into an offset (action 1) for an array of up to MAX_AXES axes.
// Shape comes from the write port: index 0 is the axis count, 1..4 the extents.
// Write the shape only while no item is in flight.
// One beat in gives one beat out, in order. Items are worked one at a time.
// Action 0 runs the bit-serial divider once per axis in use. Action 1
// folds coordinates by Horner steps on the shift-add multiplier.
// A bad coordinate or a zero extent is flagged at acceptance and goes
// straight to the done state; an offset past the element count runs all
// divisions first.
// The result sits in an output register; a new beat is taken while it
// waits, and that next result holds until the receiver takes the first.
// Reset gives one axis of extent 1 and an empty output register.
`timescale 1ns / 1ps
module nd_index_offset_converter #(
  parameter int MAX_AXES    = nioc_pkg::MAX_AXES_DEF,
  parameter int EXTENT_BITS = nioc_pkg::EXTENT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nioc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nioc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  nioc_in_if.sink                         in_i,
  nioc_out_if.source                      out_o
);
  import nioc_pkg::*;

  localparam int EW  = (EXTENT_BITS < EXT_FIELD_W) ? EXTENT_BITS : EXT_FIELD_W;
  localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  nioc_state_e state_q, state_d;

  logic [NDIMS_W-1:0]     num_dims_q;
  logic [EW-1:0]          ext_q [MAX_AXES];

  logic                   action_q;
  logic                   bad_q;
  logic [OFFSET_W-1:0]    work_q;
  logic [COORD_IN_W-1:0]  cin_q [MAX_AXES];
  logic [EW-1:0]          cres_q [MAX_AXES];
  logic [AXW-1:0]         ax_q;

  logic                   out_valid_q;
  logic                   status_q;
  logic [OFFSET_W-1:0]    offset_q;
  logic [COORD_OUT_W-1:0] cout_q [FIELD_AXES];
  logic [COORD_OUT_W-1:0] cres_full [FIELD_AXES];

  logic [COORD_IN_W-1:0]  cin_w [FIELD_AXES];
  logic [AXW-1:0]         last_ax;
  logic                   bad_in;
  logic                   accept;
  logic                   in_ready;
  logic                   div_start;
  logic                   mul_start;
  logic                   load_out;
  logic                   last_step;
  logic                   unit_done;

  logic                   div_done;
  logic [OFFSET_W-1:0]    div_q;
  logic [EW-1:0]          div_r;
  logic                   mul_done;
  logic [OFFSET_W-1:0]    mul_p;

  assign cin_w[0] = in_i.coord_in0;
  assign cin_w[1] = in_i.coord_in1;
  assign cin_w[2] = in_i.coord_in2;
  assign cin_w[3] = in_i.coord_in3;

  always_comb begin
    if (num_dims_q == '0) begin
      last_ax = '0;
    end else if (int'(num_dims_q) > MAX_AXES) begin
      last_ax = AXW'(MAX_AXES - 1);
    end else begin
      last_ax = AXW'(num_dims_q - NDIMS_W'(1));
    end
  end

  always_comb begin
    bad_in = 1'b0;
    for (int i = 0; i < MAX_AXES; i++) begin
      if (AXW'(i) <= last_ax) begin
        if (in_i.action == ACT_SPLIT) begin
          if (ext_q[i] == '0) begin
            bad_in = 1'b1;
          end
        end else if (cin_w[i][COORD_IN_W-1] ||
                     ({1'b0, cin_w[i][COORD_OUT_W-1:0]} >= COORD_IN_W'(ext_q[i]))) begin
          bad_in = 1'b1;
        end
      end
    end
  end

  assign accept    = in_i.valid && in_ready;
  assign unit_done = (action_q == ACT_FOLD) ? mul_done : div_done;
  assign last_step = (action_q == ACT_FOLD) ? (ax_q == '0) : (ax_q == last_ax);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = bad_in ? ST_DONE : ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_d = ST_WAIT;
      ST_WAIT: begin
        if (unit_done) begin
          state_d = last_step ? ST_DONE : ST_LAUNCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_LAUNCH: begin
        div_start = (action_q == ACT_SPLIT);
        mul_start = (action_q == ACT_FOLD);
      end
      ST_WAIT:   ;
      ST_DONE:   load_out = !out_valid_q || out_o.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      num_dims_q  <= NDIMS_W'(1);
      for (int i = 0; i < MAX_AXES; i++) begin
        ext_q[i] <= EW'(1);
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_NUM_DIMS) begin
          num_dims_q <= cfg_wdata_i[NDIMS_W-1:0];
        end
        for (int i = 0; i < MAX_AXES; i++) begin
          if (cfg_idx_i == CFG_IDX_W'(REG_EXT0 + i)) begin
            ext_q[i] <= cfg_wdata_i[EW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_i.action;
      bad_q    <= bad_in;
      for (int i = 0; i < MAX_AXES; i++) begin
        cin_q[i]  <= cin_w[i];
        cres_q[i] <= '0;
      end
      if (in_i.action == ACT_SPLIT) begin
        work_q <= in_i.lin_offset;
        ax_q   <= '0;
      end else begin
        work_q <= '0;
        ax_q   <= last_ax;
      end
    end else if ((state_q == ST_WAIT) && unit_done) begin
      if (action_q == ACT_SPLIT) begin
        work_q       <= div_q;
        cres_q[ax_q] <= div_r;
        if (last_step) begin
          bad_q <= (div_q != '0);
        end else begin
          ax_q <= ax_q + AXW'(1);
        end
      end else begin
        work_q <= mul_p;
        if (!last_step) begin
          ax_q <= ax_q - AXW'(1);
        end
      end
    end

    if (load_out) begin
      status_q <= bad_q ? STATUS_RANGE : STATUS_OK;
      offset_q <= (bad_q || (action_q == ACT_SPLIT)) ? '0 : work_q;
      for (int j = 0; j < FIELD_AXES; j++) begin
        cout_q[j] <= (bad_q || (action_q == ACT_FOLD)) ? '0 : cres_full[j];
      end
    end
  end

  for (genvar j = 0; j < FIELD_AXES; j++) begin : g_cres
    if (j < MAX_AXES) begin : g_used
      assign cres_full[j] = COORD_OUT_W'(cres_q[j]);
    end else begin : g_unused
      assign cres_full[j] = '0;
    end
  end

  nioc_div #(
    .DW (EW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (work_q),
    .d_i     (ext_q[ax_q]),
    .done_o  (div_done),
    .q_o     (div_q),
    .r_o     (div_r)
  );

  nioc_mul #(
    .BW (EW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (work_q),
    .b_i     (ext_q[ax_q]),
    .c_i     (OFFSET_W'(cin_q[ax_q][COORD_OUT_W-1:0])),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.offset_out = offset_q;
  assign out_o.coord_out0 = cout_q[0];
  assign out_o.coord_out1 = cout_q[1];
  assign out_o.coord_out2 = cout_q[2];
  assign out_o.coord_out3 = cout_q[3];

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done || mul_done) |-> (state_q == ST_WAIT))
    else $error("arithmetic unit finished outside of wait state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted beat did not start work");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result register loaded outside of done state");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == STATUS_RANGE)) |->
      ((offset_q == '0) && (cout_q[0] == '0) && (cout_q[1] == '0) &&
       (cout_q[2] == '0) && (cout_q[3] == '0)))
    else $error("error beat carries nonzero payload");

endmodule

// ===== bench/nioc_result_checker.sv =====
// nioc_result_checker: watches the converter's config port and both channels,
// predicts each result beat from the shape and compares it field by field.
// Depends on nioc_pkg, nioc_in_if and nioc_out_if.
`timescale 1ns / 1ps
module nioc_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nioc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nioc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  nioc_in_if                              in_mon,
  nioc_out_if                             out_mon,
  output int                              pending_o,
  output int                              fail_cnt_o
);
  import nioc_pkg::*;

  typedef struct packed {
    logic                                   status;
    logic [OFFSET_W-1:0]                    offset;
    logic [FIELD_AXES-1:0][COORD_OUT_W-1:0] coord;
  } conv_beat_t;

  logic [NDIMS_W-1:0]                     ndims_q;
  logic [FIELD_AXES-1:0][EXT_FIELD_W-1:0] extent_q;
  conv_beat_t                             expected_beats[$];
  int                                     mismatches;

  function automatic conv_beat_t convert_beat(logic act, logic [OFFSET_W-1:0] off,
                                              logic [FIELD_AXES-1:0][COORD_IN_W-1:0] crd_in);
    conv_beat_t      r;
    int unsigned     axes;
    int              i;
    longint unsigned elems, rest, acc, weight;
    longint          crd;
    logic            bad;
    r      = '0;
    bad    = 1'b0;
    elems  = 1;
    acc    = 0;
    weight = 1;
    axes   = (ndims_q == 0) ? 1 : ((ndims_q > MAX_AXES_DEF) ? MAX_AXES_DEF : ndims_q);
    for (i = 0; i < FIELD_AXES; i++) begin
      if (i < axes) elems *= extent_q[i];
    end
    if (act == ACT_SPLIT) begin
      rest = off;
      if (rest >= elems) begin
        bad = 1'b1;
      end else begin
        for (i = 0; i < FIELD_AXES; i++) begin
          if (i < axes) begin
            r.coord[i] = COORD_OUT_W'(rest % extent_q[i]);
            rest       = rest / extent_q[i];
          end
        end
      end
    end else begin
      for (i = 0; i < FIELD_AXES; i++) begin
        if (i < axes && !bad) begin
          crd = longint'($signed(crd_in[i]));
          if (crd < 0 || crd >= longint'(extent_q[i])) begin
            bad = 1'b1;
          end else begin
            acc    += $unsigned(crd) * weight;
            weight *= extent_q[i];
          end
        end
      end
      if (!bad) r.offset = acc[OFFSET_W-1:0];
    end
    if (bad) begin
      r        = '0;
      r.status = STATUS_RANGE;
    end
    return r;
  endfunction

  task automatic compare_beat(conv_beat_t want, conv_beat_t got);
    int i;
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.offset !== want.offset) begin
      $display("%0t: offset_out expected %0h actual %0h", $time, want.offset, got.offset);
      mismatches++;
    end
    for (i = 0; i < FIELD_AXES; i++) begin
      if (got.coord[i] !== want.coord[i]) begin
        $display("%0t: coord_out%0d expected %0d actual %0d", $time, i, want.coord[i],
                 got.coord[i]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conv_beat_t got;
    if (!rst_ni) begin
      ndims_q  = NDIMS_W'(1);
      extent_q = {FIELD_AXES{EXT_FIELD_W'(1)}};
      expected_beats.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_NUM_DIMS) begin
          ndims_q = cfg_wdata_i[NDIMS_W-1:0];
        end else if (cfg_idx_i >= REG_EXT0 && cfg_idx_i < REG_EXT0 + FIELD_AXES) begin
          extent_q[cfg_idx_i - REG_EXT0] = cfg_wdata_i[EXT_FIELD_W-1:0];
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{status: out_mon.status, offset: out_mon.offset_out,
                coord: {out_mon.coord_out3, out_mon.coord_out2, out_mon.coord_out1,
                        out_mon.coord_out0}};
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d offset %0h",
                   $time, got.status, got.offset);
          mismatches++;
        end else begin
          compare_beat(expected_beats.pop_front(), got);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_beats.push_back(convert_beat(in_mon.action, in_mon.lin_offset,
                                              {in_mon.coord_in3, in_mon.coord_in2,
                                               in_mon.coord_in1, in_mon.coord_in0}));
      end
    end
    pending_o  <= expected_beats.size();
    fail_cnt_o <= mismatches;
  end

endmodule

// ===== bench/nd_index_offset_converter_test.sv =====
// nd_index_offset_converter_test: drives shapes, offsets and coordinates into
// the converter with random idling and a long output hold; the checker judges.
// Depends on nioc_pkg, both channel interfaces, the converter and nioc_result_checker.
`timescale 1ns / 1ps
module nd_index_offset_converter_test;
  import nioc_pkg::*;

  localparam int HOLD_CYCLES     = 800;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int PHASE_BEATS     = 65;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    fail_cnt;
  bit                    idle_en;
  bit                    hold_req;
  int                    shape_nd;
  int                    shape_ext[FIELD_AXES];

  nioc_in_if  in_if ();
  nioc_out_if out_if ();

  nd_index_offset_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  nioc_result_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .pending_o   (pending),
    .fail_cnt_o  (fail_cnt)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [FIELD_AXES-1:0][COORD_IN_W-1:0] coords(int c0, int c1, int c2,
                                                                    int c3);
    return {COORD_IN_W'(c3), COORD_IN_W'(c2), COORD_IN_W'(c1), COORD_IN_W'(c0)};
  endfunction

  task automatic write_shape(int nd, int e0, int e1, int e2, int e3);
    int r;
    int vals[5];
    vals = '{nd, e0, e1, e2, e3};
    for (r = 0; r < 5; r++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= (r == 0) ? REG_NUM_DIMS : CFG_IDX_W'(REG_EXT0 + r - 1);
      cfg_wdata <= CFG_DATA_W'(vals[r]);
      @(posedge clk_i);
    end
    cfg_we   <= 1'b0;
    shape_nd = nd;
    for (r = 0; r < FIELD_AXES; r++) shape_ext[r] = vals[r + 1] & 12'hfff;
  endtask

  task automatic send_beat(logic act, logic [OFFSET_W-1:0] off,
                           logic [FIELD_AXES-1:0][COORD_IN_W-1:0] crd);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.lin_offset <= off;
    in_if.coord_in0  <= crd[0];
    in_if.coord_in1  <= crd[1];
    in_if.coord_in2  <= crd[2];
    in_if.coord_in3  <= crd[3];
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // mostly in-range beats with random content, some just past the edge, some noise
  task automatic send_random_beat();
    logic                                  act;
    logic [OFFSET_W-1:0]                   off;
    logic [FIELD_AXES-1:0][COORD_IN_W-1:0] crd;
    longint unsigned                       elems;
    int                                    axes;
    int                                    pick;
    int                                    ax;
    int                                    i;
    act   = $urandom_range(0, 1) ? ACT_FOLD : ACT_SPLIT;
    off   = OFFSET_W'({$urandom, $urandom});
    axes  = (shape_nd == 0) ? 1 : ((shape_nd > MAX_AXES_DEF) ? MAX_AXES_DEF : shape_nd);
    elems = 1;
    for (i = 0; i < FIELD_AXES; i++) begin
      crd[i] = COORD_IN_W'($urandom);
      if (i < axes) elems *= shape_ext[i];
    end
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      if (elems != 0) off = OFFSET_W'({$urandom, $urandom} % elems);
      for (i = 0; i < axes; i++) begin
        if (shape_ext[i] != 0) crd[i] = COORD_IN_W'($urandom_range(0, shape_ext[i] - 1));
      end
    end else if (pick == 8) begin
      off    = OFFSET_W'(elems + $urandom_range(0, 3));
      ax     = $urandom_range(0, axes - 1);
      crd[ax] = $urandom_range(0, 1) ? COORD_IN_W'(shape_ext[ax]) : COORD_IN_W'(-1);
    end
    send_beat(act, off, crd);
  endtask

  // the count seen at the accepting edge is still the old one, so wait for the next edge before looking
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(int nd, int e0, int e1, int e2, int e3);
    write_shape(nd, e0, e1, e2, e3);
    repeat (PHASE_BEATS) send_random_beat();
    drain();
  endtask

  function automatic int random_extent();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick < 4) return $urandom_range(1, 4095);
    return $urandom_range(1, 16);
  endfunction

  // output side: random stalls, one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("nd_index_offset_converter regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int k;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.action     <= ACT_SPLIT;
    in_if.lin_offset <= '0;
    in_if.coord_in0  <= '0;
    in_if.coord_in1  <= '0;
    in_if.coord_in2  <= '0;
    in_if.coord_in3  <= '0;
    idle_en  = 1'b1;
    hold_req = 1'b0;
    shape_nd = 1;
    for (k = 0; k < FIELD_AXES; k++) shape_ext[k] = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset shape: one axis of length 1
    send_beat(ACT_SPLIT, '0, '0);
    send_beat(ACT_SPLIT, OFFSET_W'(1), '0);
    send_beat(ACT_FOLD, '0, coords(0, -4096, 4095, -1));
    send_beat(ACT_FOLD, '0, coords(1, 0, 0, 0));
    drain();

    write_shape(3, 5, 4095, 3, 0);
    send_beat(ACT_SPLIT, '0, '0);
    send_beat(ACT_SPLIT, OFFSET_W'(5), '0);
    send_beat(ACT_SPLIT, OFFSET_W'(61424), '0);
    send_beat(ACT_SPLIT, OFFSET_W'(61425), '0);
    send_beat(ACT_SPLIT, '1, '1);
    send_beat(ACT_SPLIT, {1'b1, {(OFFSET_W-1){1'b0}}}, '0);
    send_beat(ACT_FOLD, '1, coords(0, 0, 0, 0));
    send_beat(ACT_FOLD, '0, coords(4, 4094, 2, -4096));
    send_beat(ACT_FOLD, '0, coords(2, 100, 1, 4095));
    send_beat(ACT_FOLD, '0, coords(-1, 0, 0, 0));
    send_beat(ACT_FOLD, '0, coords(0, -4096, 0, 0));
    send_beat(ACT_FOLD, '0, coords(0, 0, 3, 0));
    send_beat(ACT_FOLD, '0, coords(4095, 0, 0, 0));
    send_beat(ACT_FOLD, '0, coords(5, 0, 0, 0));
    send_beat(ACT_FOLD, '0, coords(0, 4095, 1, 0));
    drain();

    run_phase(4, 4095, 4095, 4095, 4095);
    hold_req = 1'b1;
    run_phase(2, 7, 5, 1, 1);
    run_phase(3, 1, 4095, 3, 2);
    run_phase(0, 13, 2, 2, 2);
    run_phase(7, 2, 3, 4, 5);
    run_phase(4, 6, 5, 0, 3);
    run_phase(1, 0, 9, 9, 9);
    run_phase(2, 9, 11, 17, 0);
    run_phase(5, 4095, 1, 4095, 1);
    run_phase(4, 1, 1, 1, 1);
    for (k = 0; k < 14; k++) begin
      if (k >= 11) idle_en = 1'b0;
      run_phase($urandom_range(0, 7), random_extent(), random_extent(), random_extent(),
                random_extent());
    end

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("nd_index_offset_converter regression: pass");
    end else begin
      $display("nd_index_offset_converter regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nioc_pkg.sv
rtl/nioc_in_if.sv
rtl/nioc_out_if.sv
rtl/nioc_div.sv
rtl/nioc_mul.sv
rtl/nd_index_offset_converter.sv
bench/nioc_result_checker.sv
bench/nd_index_offset_converter_test.sv
